// File: hdl/ptae_pkg.sv
`default_nettype none
package ptae_pkg;

	// Q47.16 accumulator limits
	localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0000;

	// controller commands to the datapath
	typedef struct packed {
		logic capture;   // latch input word, clear accumulator and flag
		logic rd_exp;    // read table at the word's exponent
		logic rd_idx;    // read table at the Horner index
		logic wr_term;   // write accumulated coefficient back
		logic mul_lo;    // low partial product
		logic mul_hi;    // high partial product
		logic mul_fix;   // combine, floor shift and clip the product
		logic add_coef;  // add coefficient with clipping, step index down
		logic out_load;  // move accumulator into the result register
	} cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic idx_zero;
	} stat_t;

endpackage
`default_nettype wire

// File: hdl/polynomial_term_accumulate_evaluate.sv
`default_nettype none
// channel  | valid     | ready     | fields
// ---------+-----------+-----------+-------------------------------------------
// input    | in_valid  | in_ready  | action, exponent, coefficient, x_value
// output   | out_valid | out_ready | poly_value, saturated
//
// Add-term word: accept, table read, write back; no result.
// Evaluate word: each Horner step does the split 64x32 multiply as a low and a
// high partial product, then shift and clip, then the coefficient add. Reset
// empties the table at once through per-entry valid bits. A waiting result does
// not block new words; only a second result stalls.
module polynomial_term_accumulate_evaluate #(
	parameter int MAX_DEGREE = 15
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [3:0]         exponent,
	input  wire logic signed [31:0] coefficient,
	input  wire logic signed [31:0] x_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [63:0]      poly_value,
	output logic                    saturated
);

	import ptae_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ptae_dpath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.exponent    (exponent),
		.coefficient (coefficient),
		.x_value     (x_value),
		.poly_value  (poly_value),
		.saturated   (saturated)
	);

	ptae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire

// File: hdl/ptae_ram.sv
`default_nettype none
module ptae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/ptae_ctrl.sv
`default_nettype none
module ptae_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            action,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ptae_pkg::cmd_t       cmd,
	input  wire ptae_pkg::stat_t stat
);

	import ptae_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_ADD_RD = 8'b0000_0010,
		ST_ADD_WR = 8'b0000_0100,
		ST_MUL_LO = 8'b0000_1000,
		ST_MUL_HI = 8'b0001_0000,
		ST_FIX    = 8'b0010_0000,
		ST_ADD    = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_fire;
				if (in_fire) begin
					state_nxt = action ? ST_MUL_LO : ST_ADD_RD;
				end
			end
			ST_ADD_RD: begin
				cmd.rd_exp = 1'b1;
				state_nxt  = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd.wr_term = 1'b1;
				state_nxt   = ST_IDLE;
			end
			ST_MUL_LO: begin
				cmd.rd_idx = 1'b1;
				cmd.mul_lo = 1'b1;
				state_nxt  = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_nxt  = ST_FIX;
			end
			ST_FIX: begin
				cmd.mul_fix = 1'b1;
				state_nxt   = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_coef = 1'b1;
				state_nxt    = stat.idx_zero ? ST_FINISH : ST_MUL_LO;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// advance state, hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && !out_ready) |=> (state_q == ST_FINISH))
		else $error("result overwritten while previous word still waiting");
	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && action) |=> (state_q == ST_MUL_LO))
		else $error("evaluate word did not start Horner walk");
	a_add_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_RD) |=> (state_q == ST_ADD_WR))
		else $error("table read not followed by write back");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register loaded while occupied");
`endif

endmodule
`default_nettype wire

// File: hdl/ptae_dpath.sv
`default_nettype none
module ptae_dpath #(
	parameter int MAX_DEGREE = 15
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ptae_pkg::cmd_t        cmd,
	output ptae_pkg::stat_t            stat,
	input  wire logic [3:0]            exponent,
	input  wire logic signed [31:0]    coefficient,
	input  wire logic signed [31:0]    x_value,
	output logic signed [63:0]         poly_value,
	output logic                       saturated
);

	import ptae_pkg::*;

	localparam int DEPTH = MAX_DEGREE + 1;
	localparam int IDX_W = $clog2(DEPTH);

	logic [3:0]         exp_q;
	logic [31:0]        coef_q;
	logic signed [31:0] x_q;
	logic [63:0]        acc_q;
	logic               sat_q;
	logic [IDX_W-1:0]   idx_q;
	logic [DEPTH-1:0]   vld_q;
	logic               vld_rd_q;
	logic signed [64:0] plo_q;
	logic signed [63:0] phi_q;
	logic [63:0]        poly_q;
	logic               sat_out_q;

	logic               exp_ok;
	logic [IDX_W-1:0]   exp_idx;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_en;
	logic               wr_en;
	logic [31:0]        rd_data;
	logic [31:0]        coef_rd;
	logic [31:0]        wr_data;
	logic signed [32:0] acc_lo_s;
	logic signed [31:0] acc_hi_s;
	logic [95:0]        prod;
	logic               ovf_m;
	logic [63:0]        prod_clip;
	logic [63:0]        term;
	logic [63:0]        sum;
	logic               ovf_a;
	logic [63:0]        sum_clip;

	// table access: exponent for term add, Horner index for evaluate
	assign exp_ok  = int'(exp_q) <= MAX_DEGREE;
	assign exp_idx = IDX_W'(exp_q);
	assign rd_en   = cmd.rd_exp || cmd.rd_idx;
	assign rd_addr = cmd.rd_exp ? exp_idx : idx_q;
	assign wr_en   = cmd.wr_term && exp_ok;
	assign coef_rd = vld_rd_q ? rd_data : 32'd0;
	assign wr_data = coef_rd + coef_q;

	ptae_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (exp_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// product acc * x split in two 32-bit halves of acc
	assign acc_lo_s = {1'b0, acc_q[31:0]};
	assign acc_hi_s = acc_q[63:32];
	assign prod     = {phi_q, 32'd0} + {{31{plo_q[64]}}, plo_q};
	// floor shift by 16, clip when bits 95..79 are not all sign
	assign ovf_m     = !((&prod[95:79]) || !(|prod[95:79]));
	assign prod_clip = ovf_m ? (prod[95] ? ACC_MIN : ACC_MAX) : prod[79:16];

	// coefficient widened to Q47.16, add with clipping
	assign term     = {{16{coef_rd[31]}}, coef_rd, 16'd0};
	assign sum      = acc_q + term;
	assign ovf_a    = (acc_q[63] == term[63]) && (sum[63] != acc_q[63]);
	assign sum_clip = ovf_a ? (acc_q[63] ? ACC_MIN : ACC_MAX) : sum;

	assign stat.idx_zero = (idx_q == '0);
	assign poly_value    = poly_q;
	assign saturated     = sat_out_q;

	// valid bits: an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[exp_idx] <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			exp_q  <= exponent;
			coef_q <= coefficient;
			x_q    <= x_value;
			acc_q  <= 64'd0;
			sat_q  <= 1'b0;
			idx_q  <= IDX_W'(MAX_DEGREE);
		end
		if (rd_en) begin
			vld_rd_q <= vld_q[rd_addr];
		end
		if (cmd.mul_lo) begin
			plo_q <= 65'(acc_lo_s) * 65'(x_q);
		end
		if (cmd.mul_hi) begin
			phi_q <= 64'(acc_hi_s) * 64'(x_q);
		end
		if (cmd.mul_fix) begin
			acc_q <= prod_clip;
			sat_q <= sat_q || ovf_m;
		end
		if (cmd.add_coef) begin
			acc_q <= sum_clip;
			sat_q <= sat_q || ovf_a;
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.out_load) begin
			poly_q    <= acc_q;
			sat_out_q <= sat_q;
		end
	end

endmodule
`default_nettype wire
